/* hw/rtl/swap_frame_allocator_assert.svh */
// Assertion macros for the swap frame allocator.
`ifndef SWAP_FRAME_ALLOCATOR_ASSERT_SVH
`define SWAP_FRAME_ALLOCATOR_ASSERT_SVH
`ifndef ASSERT_OFF
`define SFA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SFA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SFA_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SFA_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* hw/rtl/sfa_pkg.sv */
`default_nettype none
package sfa_pkg;
    localparam int MAX_PARTITIONS  = 8;
    localparam int MAX_FPP         = 64;
    localparam int PROCESS_SLOTS   = 32;
    localparam int TOTAL_FRAMES    = MAX_PARTITIONS * MAX_FPP;
    localparam int WORD_W          = 64;
    localparam int NUM_WORDS       = TOTAL_FRAMES / WORD_W;
    localparam int WADDR_W         = $clog2(NUM_WORDS);
    localparam int BIT_W           = $clog2(WORD_W);
    localparam int FRAME_W         = 9;
    localparam int SLOT_W          = $clog2(PROCESS_SLOTS);
    localparam int PART_W          = 3;
    localparam int CNT_W           = 7;
    localparam int PID_W           = 16;
    localparam int PC_W            = 4;
    localparam int CFG_IDX_W       = 1;
    localparam int CFG_DATA_W      = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_FPP = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PC  = 1'b1;

    typedef enum logic [2:0] {
        MODE_CREATE, MODE_ALLOC, MODE_COUNT, MODE_FREE, MODE_REMOVE, MODE_EXISTS
    } t_mode;

    typedef enum logic [2:0] {
        STAT_OK, STAT_NO_SPACE, STAT_UNKNOWN_PID, STAT_NOT_OWNED, STAT_TABLE_FULL
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE, S_SLOT_RD, S_SLOT_CHK, S_DISPATCH, S_SCAN_INIT, S_SCAN_RD,
        S_SCAN_EVAL, S_FREE_RD, S_FREE_CHK, S_DONE
    } t_state;

    typedef enum logic [1:0] {SCAN_COUNT, SCAN_BEST, SCAN_ALLOC} t_scan;

    typedef struct packed {
        logic [2:0]         mode;
        logic [PID_W-1:0]   pid;
        logic [FRAME_W-1:0] frame_id;
    } t_in_item;

    typedef struct packed {
        logic [2:0]         status;
        logic [FRAME_W-1:0] frame_number;
        logic [CNT_W-1:0]   free_count;
        logic [PART_W-1:0]  partition_index;
        logic               pid_found;
    } t_out_item;

    typedef struct packed {
        logic               bm_rd_en;
        logic               bm_we;
        logic [WADDR_W-1:0] bm_addr;
        logic [WORD_W-1:0]  bm_wdata;
        logic               own_rd_en;
        logic               own_we;
        logic [FRAME_W-1:0] own_addr;
        logic [PID_W-1:0]   own_wdata;
        logic               slot_rd_en;
        logic               slot_we;
        logic [SLOT_W-1:0]  slot_addr;
        logic [PID_W-1:0]   slot_wpid;
        logic [PART_W-1:0]  slot_wpart;
    } t_mem_req;

    typedef struct packed {
        logic [WORD_W-1:0]  bm_rdata;
        logic [PID_W-1:0]   own_rdata;
        logic [PID_W-1:0]   slot_rpid;
        logic [PART_W-1:0]  slot_rpart;
    } t_mem_rsp;

    function automatic logic [CNT_W-1:0] popcount_word(input logic [WORD_W-1:0] v);
        logic [CNT_W-1:0] n;
        n = '0;
        for (int i = 0; i < WORD_W; i++) begin
            n = n + CNT_W'(v[i]);
        end
        return n;
    endfunction

    function automatic logic [BIT_W-1:0] first_one(input logic [WORD_W-1:0] v);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (v[i]) idx = BIT_W'(i);
        end
        return idx;
    endfunction
endpackage
`default_nettype wire

/* hw/rtl/sfa_store.sv */
`default_nettype none
module sfa_store (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire sfa_pkg::t_mem_req i_req,
    output sfa_pkg::t_mem_rsp      o_rsp
);
    import sfa_pkg::*;

    logic [WORD_W-1:0]        bm_mem [NUM_WORDS];
    logic [PID_W-1:0]         own_mem [TOTAL_FRAMES];
    logic [PID_W+PART_W-1:0]  slot_mem [PROCESS_SLOTS];
    logic [NUM_WORDS-1:0]     r_bm_valid;
    logic                     r_bm_rvalid;
    logic [WORD_W-1:0]        r_bm_rdata;
    logic [PID_W-1:0]         r_own_rdata;
    logic [PID_W+PART_W-1:0]  r_slot_rdata;

    // word valid bits stand in for the all-free reset of the bitmap
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bm_valid <= '0;
        end else if (i_req.bm_we) begin
            r_bm_valid[i_req.bm_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.bm_we) bm_mem[i_req.bm_addr] <= i_req.bm_wdata;
        if (i_req.bm_rd_en) begin
            r_bm_rdata  <= bm_mem[i_req.bm_addr];
            r_bm_rvalid <= r_bm_valid[i_req.bm_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.own_we) own_mem[i_req.own_addr] <= i_req.own_wdata;
        if (i_req.own_rd_en) r_own_rdata <= own_mem[i_req.own_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_req.slot_we) slot_mem[i_req.slot_addr] <= {i_req.slot_wpid, i_req.slot_wpart};
        if (i_req.slot_rd_en) r_slot_rdata <= slot_mem[i_req.slot_addr];
    end

    assign o_rsp.bm_rdata   = r_bm_rvalid ? r_bm_rdata : '0;
    assign o_rsp.own_rdata  = r_own_rdata;
    assign o_rsp.slot_rpid  = r_slot_rdata[PID_W+PART_W-1:PART_W];
    assign o_rsp.slot_rpart = r_slot_rdata[PART_W-1:0];
endmodule
`default_nettype wire

/* hw/rtl/sfa_ctrl.sv */
`default_nettype none
module sfa_ctrl (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire sfa_pkg::t_in_item            i_item,
    input  wire logic [sfa_pkg::CNT_W-1:0]    i_fpp,
    input  wire logic [sfa_pkg::PART_W-1:0]   i_last_part,
    input  wire sfa_pkg::t_mem_rsp            i_rsp,
    output sfa_pkg::t_mem_req                 o_req,
    output logic                              o_busy,
    output logic                              o_done,
    output sfa_pkg::t_out_item                o_result
);
    import sfa_pkg::*;

    t_state                r_state, n_state;
    t_scan                 r_kind, n_kind;
    t_in_item              r_item, n_item;
    logic [SLOT_W-1:0]     r_slot_idx, n_slot_idx;
    logic                  r_found, n_found;
    logic [SLOT_W-1:0]     r_hit, n_hit;
    logic [PART_W-1:0]     r_part, n_part;
    logic [PART_W-1:0]     r_cur, n_cur;
    logic [WADDR_W-1:0]    r_word, n_word;
    logic [CNT_W-1:0]      r_acc, n_acc;
    logic [CNT_W-1:0]      r_best, n_best;
    logic [PART_W-1:0]     r_bestp, n_bestp;
    t_status               r_status, n_status;
    logic [FRAME_W-1:0]    r_frame, n_frame;
    logic [CNT_W-1:0]      r_freec, n_freec;
    logic [PART_W-1:0]     r_opart, n_opart;
    logic                  r_ofound, n_ofound;
    logic [PROCESS_SLOTS-1:0] r_valid, n_valid;

    logic [FRAME_W:0]      w_start_x, w_end_x;
    logic [FRAME_W-1:0]    w_start, w_end;
    logic [WADDR_W-1:0]    w_ws, w_we;
    logic [BIT_W-1:0]      w_lo, w_hi;
    logic [WORD_W-1:0]     w_mask, w_free_bits;
    logic [CNT_W-1:0]      w_pop, w_sum;
    logic [BIT_W-1:0]      w_first;
    logic [SLOT_W-1:0]     w_free_slot;
    logic                  w_table_full;
    logic                  w_new_best;
    logic [CNT_W-1:0]      w_bb;
    logic [PART_W-1:0]     w_bp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind     <= n_kind;
        r_item     <= n_item;
        r_slot_idx <= n_slot_idx;
        r_found    <= n_found;
        r_hit      <= n_hit;
        r_part     <= n_part;
        r_cur      <= n_cur;
        r_word     <= n_word;
        r_acc      <= n_acc;
        r_best     <= n_best;
        r_bestp    <= n_bestp;
        r_status   <= n_status;
        r_frame    <= n_frame;
        r_freec    <= n_freec;
        r_opart    <= n_opart;
        r_ofound   <= n_ofound;
    end

    // span of the partition under scan
    always_comb begin
        w_start_x = (FRAME_W+1)'(r_cur) * (FRAME_W+1)'(i_fpp);
        w_end_x   = w_start_x + (FRAME_W+1)'(i_fpp) - (FRAME_W+1)'(1);
        w_start   = w_start_x[FRAME_W-1:0];
        w_end     = w_end_x[FRAME_W-1:0];
        w_ws      = w_start[FRAME_W-1:BIT_W];
        w_we      = w_end[FRAME_W-1:BIT_W];
        w_lo      = (r_word == w_ws) ? w_start[BIT_W-1:0] : '0;
        w_hi      = (r_word == w_we) ? w_end[BIT_W-1:0] : BIT_W'(WORD_W - 1);
        w_mask    = ({WORD_W{1'b1}} << w_lo) & ({WORD_W{1'b1}} >> (BIT_W'(WORD_W - 1) - w_hi));
        w_free_bits = ~i_rsp.bm_rdata & w_mask;
        w_pop     = popcount_word(w_free_bits);
        w_sum     = r_acc + w_pop;
        w_first   = first_one(w_free_bits);
        w_new_best = w_sum > r_best;
        w_bb      = w_new_best ? w_sum : r_best;
        w_bp      = w_new_best ? r_cur : r_bestp;
    end

    always_comb begin
        w_free_slot  = '0;
        w_table_full = &r_valid;
        for (int i = PROCESS_SLOTS - 1; i >= 0; i--) begin
            if (!r_valid[i]) w_free_slot = SLOT_W'(i);
        end
    end

    always_comb begin
        n_state    = r_state;
        n_kind     = r_kind;
        n_item     = r_item;
        n_slot_idx = r_slot_idx;
        n_found    = r_found;
        n_hit      = r_hit;
        n_part     = r_part;
        n_cur      = r_cur;
        n_word     = r_word;
        n_acc      = r_acc;
        n_best     = r_best;
        n_bestp    = r_bestp;
        n_status   = r_status;
        n_frame    = r_frame;
        n_freec    = r_freec;
        n_opart    = r_opart;
        n_ofound   = r_ofound;
        n_valid    = r_valid;
        o_req      = '0;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_item     = i_item;
                    n_status   = STAT_OK;
                    n_frame    = '0;
                    n_freec    = '0;
                    n_opart    = '0;
                    n_ofound   = 1'b0;
                    n_found    = 1'b0;
                    n_slot_idx = '0;
                    if (i_item.mode > MODE_EXISTS) n_state = S_DONE;
                    else n_state = S_SLOT_RD;
                end
            end
            S_SLOT_RD: begin
                o_req.slot_rd_en = 1'b1;
                o_req.slot_addr  = r_slot_idx;
                n_state = S_SLOT_CHK;
            end
            S_SLOT_CHK: begin
                if (r_valid[r_slot_idx] && i_rsp.slot_rpid == r_item.pid) begin
                    n_found = 1'b1;
                    n_hit   = r_slot_idx;
                    n_part  = i_rsp.slot_rpart;
                    n_state = S_DISPATCH;
                end else if (r_slot_idx == SLOT_W'(PROCESS_SLOTS - 1)) begin
                    n_state = S_DISPATCH;
                end else begin
                    n_slot_idx = r_slot_idx + SLOT_W'(1);
                    n_state    = S_SLOT_RD;
                end
            end
            S_DISPATCH: begin
                n_cur = r_part;
                n_acc = '0;
                if (r_found) begin
                    n_opart  = r_part;
                    n_ofound = 1'b1;
                    n_kind   = SCAN_COUNT;
                    n_state  = S_SCAN_INIT;
                    case (r_item.mode)
                        MODE_ALLOC:  n_kind = SCAN_ALLOC;
                        MODE_FREE: begin
                            n_frame = r_item.frame_id;
                            n_state = S_FREE_RD;
                        end
                        MODE_REMOVE: begin
                            n_valid[r_hit] = 1'b0;
                            n_ofound       = 1'b0;
                        end
                        default: n_kind = SCAN_COUNT;
                    endcase
                end else if (r_item.mode == MODE_CREATE) begin
                    n_kind  = SCAN_BEST;
                    n_cur   = '0;
                    n_best  = '0;
                    n_bestp = '0;
                    n_state = S_SCAN_INIT;
                end else begin
                    n_status = STAT_UNKNOWN_PID;
                    if (r_item.mode == MODE_FREE) n_frame = r_item.frame_id;
                    n_state = S_DONE;
                end
            end
            S_SCAN_INIT: begin
                n_word  = w_ws;
                n_acc   = '0;
                n_state = S_SCAN_RD;
            end
            S_SCAN_RD: begin
                o_req.bm_rd_en = 1'b1;
                o_req.bm_addr  = r_word;
                n_state = S_SCAN_EVAL;
            end
            S_SCAN_EVAL: begin
                case (r_kind)
                    SCAN_ALLOC: begin
                        if (|w_free_bits) begin
                            n_frame         = {r_word, w_first};
                            o_req.bm_we     = 1'b1;
                            o_req.bm_addr   = r_word;
                            o_req.bm_wdata  = i_rsp.bm_rdata | (WORD_W'(1) << w_first);
                            o_req.own_we    = 1'b1;
                            o_req.own_addr  = {r_word, w_first};
                            o_req.own_wdata = r_item.pid;
                            n_kind  = SCAN_COUNT;
                            n_state = S_SCAN_INIT;
                        end else if (r_word == w_we) begin
                            n_status = STAT_NO_SPACE;
                            n_kind   = SCAN_COUNT;
                            n_state  = S_SCAN_INIT;
                        end else begin
                            n_word  = r_word + WADDR_W'(1);
                            n_state = S_SCAN_RD;
                        end
                    end
                    SCAN_BEST: begin
                        n_acc = w_sum;
                        if (r_word != w_we) begin
                            n_word  = r_word + WADDR_W'(1);
                            n_state = S_SCAN_RD;
                        end else if (r_cur != i_last_part) begin
                            n_best  = w_bb;
                            n_bestp = w_bp;
                            n_cur   = r_cur + PART_W'(1);
                            n_state = S_SCAN_INIT;
                        end else begin
                            n_state = S_DONE;
                            if (w_bb == '0) begin
                                n_status = STAT_NO_SPACE;
                            end else if (w_table_full) begin
                                n_status = STAT_TABLE_FULL;
                            end else begin
                                o_req.slot_we    = 1'b1;
                                o_req.slot_addr  = w_free_slot;
                                o_req.slot_wpid  = r_item.pid;
                                o_req.slot_wpart = w_bp;
                                n_valid[w_free_slot] = 1'b1;
                                n_opart  = w_bp;
                                n_freec  = w_bb;
                                n_ofound = 1'b1;
                            end
                        end
                    end
                    default: begin
                        n_acc = w_sum;
                        if (r_word == w_we) begin
                            n_freec = w_sum;
                            n_state = S_DONE;
                        end else begin
                            n_word  = r_word + WADDR_W'(1);
                            n_state = S_SCAN_RD;
                        end
                    end
                endcase
            end
            S_FREE_RD: begin
                o_req.bm_rd_en  = 1'b1;
                o_req.bm_addr   = r_item.frame_id[FRAME_W-1:BIT_W];
                o_req.own_rd_en = 1'b1;
                o_req.own_addr  = r_item.frame_id;
                n_state = S_FREE_CHK;
            end
            S_FREE_CHK: begin
                if (i_rsp.bm_rdata[r_item.frame_id[BIT_W-1:0]] &&
                        i_rsp.own_rdata == r_item.pid) begin
                    o_req.bm_we    = 1'b1;
                    o_req.bm_addr  = r_item.frame_id[FRAME_W-1:BIT_W];
                    o_req.bm_wdata = i_rsp.bm_rdata &
                                     ~(WORD_W'(1) << r_item.frame_id[BIT_W-1:0]);
                end else begin
                    n_status = STAT_NOT_OWNED;
                end
                n_kind  = SCAN_COUNT;
                n_state = S_SCAN_INIT;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = (r_state == S_DONE);
    assign o_result.status          = r_status;
    assign o_result.frame_number    = r_frame;
    assign o_result.free_count      = r_freec;
    assign o_result.partition_index = r_opart;
    assign o_result.pid_found       = r_ofound;
endmodule
`default_nettype wire

/* hw/rtl/swap_frame_allocator.sv */
// Channel   | Ports                          | Handshake
// ----------+--------------------------------+-------------------------------
// request   | start, busy, i_item            | beat taken when start && !busy
// result    | o_done, o_result               | one-cycle strobe, no stall
// config    | i_cfg_we, i_cfg_idx, i_cfg_data| written when i_cfg_we is high
//
// One request at a time. The slot table lookup reads one entry at a time,
// a read state then a check state for each. Each bitmap word then takes a
// read state and an evaluate state on the single bitmap read port, plus a
// setup state per partition scanned. A partition spans at most two words;
// create scans up to eight partitions, the other modes at most their own.
// Reset clears the slot valid bits and the bitmap word valid bits at once;
// no clearing pass. Results cannot be held off: o_done rises for exactly
// one cycle per request.
`default_nettype none
`include "swap_frame_allocator_assert.svh"
module swap_frame_allocator (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire sfa_pkg::t_in_item               i_item,
    output logic                                 o_done,
    output sfa_pkg::t_out_item                   o_result,
    input  wire logic                            i_cfg_we,
    input  wire logic [sfa_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [sfa_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import sfa_pkg::*;

    logic [CNT_W-1:0]  r_fpp;
    logic [PC_W-1:0]   r_pc;
    logic [CNT_W-1:0]  w_fpp_eff;
    logic [PC_W-1:0]   w_pc_eff;
    logic [PART_W-1:0] w_last_part;
    t_mem_req          w_req;
    t_mem_rsp          w_rsp;

    // configuration registers, raw as written
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fpp <= CNT_W'(MAX_FPP);
            r_pc  <= PC_W'(MAX_PARTITIONS);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FPP: r_fpp <= i_cfg_data;
                CFG_PC:  r_pc  <= i_cfg_data[PC_W-1:0];
                default: r_fpp <= r_fpp;
            endcase
        end
    end

    // saturate out-of-range values into the legal span
    always_comb begin
        if (r_fpp == '0) w_fpp_eff = CNT_W'(1);
        else if (r_fpp > CNT_W'(MAX_FPP)) w_fpp_eff = CNT_W'(MAX_FPP);
        else w_fpp_eff = r_fpp;
        if (r_pc == '0) w_pc_eff = PC_W'(1);
        else if (r_pc > PC_W'(MAX_PARTITIONS)) w_pc_eff = PC_W'(MAX_PARTITIONS);
        else w_pc_eff = r_pc;
        w_last_part = PART_W'(w_pc_eff - PC_W'(1));
    end

    sfa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_item      (i_item),
        .i_fpp       (w_fpp_eff),
        .i_last_part (w_last_part),
        .i_rsp       (w_rsp),
        .o_req       (w_req),
        .o_busy      (busy),
        .o_done      (o_done),
        .o_result    (o_result)
    );

    sfa_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    `SFA_ASSERT_NXT(a_done_single, i_clk, i_rst_n, o_done, !o_done)
    `SFA_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)
    `SFA_ASSERT_IMP(a_done_in_busy, i_clk, i_rst_n, o_done, busy)
    `SFA_ASSERT_IMP(a_status_legal, i_clk, i_rst_n, o_done, o_result.status <= STAT_TABLE_FULL)
endmodule
`default_nettype wire

/* tb/testbench.sv */
module testbench;
    import sfa_pkg::*;

    // Clock, reset and block ports
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    t_in_item i_item = '0;
    logic o_done;
    t_out_item o_result;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = CFG_FPP;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    always #6 i_clk = ~i_clk;

    swap_frame_allocator u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_item(i_item), .o_done(o_done), .o_result(o_result),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    // Shadow copy of the allocator state
    bit              shadow_used [TOTAL_FRAMES];
    bit [PID_W-1:0]  shadow_owner [TOTAL_FRAMES];
    bit              shadow_valid [PROCESS_SLOTS];
    bit [PID_W-1:0]  shadow_pid [PROCESS_SLOTS];
    bit [PART_W-1:0] shadow_part [PROCESS_SLOTS];
    int unsigned     cfg_fpp = 64;
    int unsigned     cfg_pc = 8;

    t_out_item pending_results[$];
    int        fail_count = 0;
    int        beat_count = 0;
    int        result_count = 0;
    int        cycle_count = 0;
    bit        gaps_on = 1'b1;
    int        mode_hits [8];

    function automatic int unsigned eff_fpp();
        if (cfg_fpp < 1) return 1;
        if (cfg_fpp > MAX_FPP) return MAX_FPP;
        return cfg_fpp;
    endfunction

    function automatic int unsigned eff_pc();
        if (cfg_pc < 1) return 1;
        if (cfg_pc > MAX_PARTITIONS) return MAX_PARTITIONS;
        return cfg_pc;
    endfunction

    function automatic int unsigned free_in_part(int unsigned part);
        int unsigned f;
        int unsigned n;
        f = eff_fpp();
        n = 0;
        for (int unsigned i = 0; i < f; i++)
            if (part * f + i < TOTAL_FRAMES && !shadow_used[part * f + i]) n++;
        return n;
    endfunction

    function automatic int lookup_slot(bit [PID_W-1:0] pid);
        for (int s = 0; s < PROCESS_SLOTS; s++)
            if (shadow_valid[s] && shadow_pid[s] == pid) return s;
        return -1;
    endfunction

    // Advance the shadow state by one request and return its result
    function automatic t_out_item allocate_step(t_in_item req);
        t_out_item r;
        int s;
        int fs;
        int unsigned best;
        int unsigned bestp;
        int unsigned c;
        int unsigned f;
        int unsigned k;
        r = '0;
        s = lookup_slot(req.pid);
        if (req.mode == MODE_CREATE) begin
            if (s >= 0) begin
                r.partition_index = shadow_part[s];
                r.free_count = CNT_W'(free_in_part(shadow_part[s]));
                r.pid_found = 1'b1;
            end else begin
                best = 0;
                bestp = 0;
                fs = -1;
                for (int unsigned p = 0; p < eff_pc(); p++) begin
                    c = free_in_part(p);
                    if (c > best) begin
                        best = c;
                        bestp = p;
                    end
                end
                for (int q = PROCESS_SLOTS - 1; q >= 0; q--)
                    if (!shadow_valid[q]) fs = q;
                if (best == 0) r.status = STAT_NO_SPACE;
                else if (fs < 0) r.status = STAT_TABLE_FULL;
                else begin
                    shadow_valid[fs] = 1'b1;
                    shadow_pid[fs] = req.pid;
                    shadow_part[fs] = PART_W'(bestp);
                    r.partition_index = PART_W'(bestp);
                    r.free_count = CNT_W'(best);
                    r.pid_found = 1'b1;
                end
            end
        end else if (req.mode <= MODE_EXISTS) begin
            if (s < 0) begin
                r.status = STAT_UNKNOWN_PID;
                if (req.mode == MODE_FREE) r.frame_number = req.frame_id;
            end else begin
                f = eff_fpp();
                r.partition_index = shadow_part[s];
                r.pid_found = 1'b1;
                if (req.mode == MODE_ALLOC) begin
                    r.status = STAT_NO_SPACE;
                    for (int unsigned i = 0; i < f; i++) begin
                        k = shadow_part[s] * f + i;
                        if (k < TOTAL_FRAMES && !shadow_used[k]) begin
                            shadow_used[k] = 1'b1;
                            shadow_owner[k] = req.pid;
                            r.frame_number = FRAME_W'(k);
                            r.status = STAT_OK;
                            break;
                        end
                    end
                end else if (req.mode == MODE_FREE) begin
                    r.frame_number = req.frame_id;
                    if (shadow_used[req.frame_id] && shadow_owner[req.frame_id] == req.pid)
                        shadow_used[req.frame_id] = 1'b0;
                    else r.status = STAT_NOT_OWNED;
                end else if (req.mode == MODE_REMOVE) begin
                    shadow_valid[s] = 1'b0;
                    r.pid_found = 1'b0;
                end
                r.free_count = CNT_W'(free_in_part(shadow_part[s]));
            end
        end
        return r;
    endfunction

    // Send one request beat; advance past the previous beat, then idle a
    // random gap when gaps are on
    task automatic send_request(bit [2:0] mode, bit [PID_W-1:0] pid, bit [FRAME_W-1:0] fid);
        t_in_item req;
        req.mode = mode;
        req.pid = pid;
        req.frame_id = fid;
        do @(posedge i_clk); while (gaps_on && $urandom_range(99) < 18);
        start <= 1'b1;
        i_item <= req;
        do @(posedge i_clk); while (busy);
        // Beat taken at this edge: predict now, before the strobe can come
        pending_results.push_back(allocate_step(req));
        mode_hits[mode]++;
        beat_count++;
        start <= 1'b0;
    endtask

    // Hold off until the block has drained every expected result
    task automatic wait_drained();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        wait_drained();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_FPP) cfg_fpp = val;
        else cfg_pc = val & 4'hF;
    endtask

    // Check every result strobe against the oldest prediction
    always @(posedge i_clk) begin
        cycle_count++;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                $error("result beat with no request outstanding");
                fail_count++;
            end else begin
                t_out_item want;
                want = pending_results.pop_front();
                result_count++;
                if (o_result.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_result.status);
                    fail_count++;
                end
                if (o_result.frame_number !== want.frame_number) begin
                    $error("frame_number: expected %0d, got %0d",
                           want.frame_number, o_result.frame_number);
                    fail_count++;
                end
                if (o_result.free_count !== want.free_count) begin
                    $error("free_count: expected %0d, got %0d",
                           want.free_count, o_result.free_count);
                    fail_count++;
                end
                if (o_result.partition_index !== want.partition_index) begin
                    $error("partition_index: expected %0d, got %0d",
                           want.partition_index, o_result.partition_index);
                    fail_count++;
                end
                if (o_result.pid_found !== want.pid_found) begin
                    $error("pid_found: expected %0d, got %0d",
                           want.pid_found, o_result.pid_found);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: allow far more than the slowest item plus gaps would need
    always @(posedge i_clk) begin
        if (cycle_count > 1200000) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Directed: edge pids, every mode, unknown pid, double create, free cases
    task automatic test_directed();
        send_request(MODE_EXISTS, 16'hFFFF, '0);
        send_request(MODE_ALLOC, 16'h0000, '0);
        send_request(MODE_FREE, 16'h1234, 9'h1FF);
        send_request(MODE_CREATE, 16'h0000, '0);
        send_request(MODE_CREATE, 16'hFFFF, '0);
        send_request(MODE_CREATE, 16'hFFFF, '0);
        send_request(MODE_ALLOC, 16'h0000, '0);
        send_request(MODE_ALLOC, 16'hFFFF, '0);
        send_request(MODE_COUNT, 16'hFFFF, '0);
        send_request(MODE_FREE, 16'hFFFF, '0);
        send_request(MODE_FREE, 16'h0000, '0);
        send_request(MODE_FREE, 16'h0000, '0);
        send_request(MODE_FREE, 16'h0000, 9'h1FF);
        send_request(MODE_REMOVE, 16'h0000, '0);
        send_request(MODE_EXISTS, 16'h0000, '0);
        send_request(MODE_COUNT, 16'h0000, '0);
        send_request(3'd6, 16'hAAAA, 9'h155);
        send_request(3'd7, 16'h5555, 9'h0AA);
    endtask

    // Tiny geometry: exhaust space and the process table
    task automatic test_full_cases();
        write_register(CFG_FPP, 7'd1);
        write_register(CFG_PC, 4'd2);
        for (int i = 0; i < 4; i++) begin
            send_request(MODE_CREATE, 16'(100 + i), '0);
            send_request(MODE_ALLOC, 16'(100 + i), '0);
        end
        write_register(CFG_FPP, 7'd64);
        write_register(CFG_PC, 4'd8);
        for (int i = 0; i < PROCESS_SLOTS + 2; i++)
            send_request(MODE_CREATE, 16'(200 + i), '0);
        for (int i = 0; i < PROCESS_SLOTS + 2; i++)
            send_request(MODE_REMOVE, 16'(200 + i), '0);
    endtask

    // Random: small pid pool so sequences of create/alloc/free hit real state
    task automatic test_random(int n, int unsigned fpp, int unsigned pc);
        bit [PID_W-1:0] pid;
        bit [2:0] mode;
        bit [FRAME_W-1:0] fid;
        int roll;
        write_register(CFG_FPP, CFG_DATA_W'(fpp));
        write_register(CFG_PC, CFG_DATA_W'(pc));
        for (int i = 0; i < n; i++) begin
            roll = $urandom_range(99);
            pid = (roll < 90) ? 16'($urandom_range(40)) : 16'($urandom);
            roll = $urandom_range(99);
            if (roll < 20) mode = MODE_CREATE;
            else if (roll < 50) mode = MODE_ALLOC;
            else if (roll < 60) mode = MODE_COUNT;
            else if (roll < 82) mode = MODE_FREE;
            else if (roll < 90) mode = MODE_REMOVE;
            else if (roll < 97) mode = MODE_EXISTS;
            else mode = 3'($urandom_range(7));
            fid = ($urandom_range(1) == 0 && fpp * pc > 0)
                ? 9'($urandom_range(eff_fpp() * eff_pc() - 1)) : 9'($urandom);
            send_request(mode, pid, fid);
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_full_cases();
        test_random(300, 64, 8);
        test_random(300, 4, 3);
        test_random(250, 0, 0);
        test_random(250, 127, 15);
        gaps_on = 1'b0;
        test_random(250, 9, 5);
        gaps_on = 1'b1;
        test_random(250, 2, 8);
        wait_drained();
        $display("Covered %0d request beats and %0d result beats over six geometries,",
                 beat_count, result_count);
        $display("modes create..exists: %0d %0d %0d %0d %0d %0d, undefined: %0d",
                 mode_hits[0], mode_hits[1], mode_hits[2], mode_hits[3], mode_hits[4],
                 mode_hits[5], mode_hits[6] + mode_hits[7]);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/sfa_pkg.sv
hw/rtl/sfa_store.sv
hw/rtl/sfa_ctrl.sv
hw/rtl/swap_frame_allocator.sv
tb/testbench.sv
